@@ rtl/gsc_pkg.sv @@
package gsc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SLIP_PRIOR     = 3'd0;
  localparam logic [2:0] REG_SLIP_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MEAN_NO_SLIP   = 3'd2;
  localparam logic [2:0] REG_SIGMA_NO_SLIP  = 3'd3;
  localparam logic [2:0] REG_MEAN_SLIPPING  = 3'd4;
  localparam logic [2:0] REG_SIGMA_SLIPPING = 3'd5;

  // Arithmetic constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [63:0] EPS_W     = 64'd5645;
  localparam logic [6:0]  EXP_MAX_N = 7'd47;

  // Divider widths and stage counts
  localparam int SQRT_LAT = 16;
  localparam int A_NUM_W  = 47;
  localparam int A_DEN_W  = 30;
  localparam int W_NUM_W  = 64;
  localparam int W_DEN_W  = 15;
  localparam int B_NUM_W  = 63;
  localparam int B_DEN_W  = 47;
  localparam int EXP_LAT  = 11;
  localparam int LIK_LAT  = 2 + A_NUM_W + EXP_LAT;
  localparam int TOTAL_LAT = 3 + SQRT_LAT + LIK_LAT + 1 + W_NUM_W + 3 + B_NUM_W + 1;

  // 2^-(1/2^(k+1)) in Q30
  function automatic logic [29:0] pow2_neg(input logic [2:0] k);
    logic [29:0] v;
    unique case (k)
      3'd0: v = 30'd759250125;
      3'd1: v = 30'd902905651;
      3'd2: v = 30'd984625595;
      3'd3: v = 30'd1028218693;
      3'd4: v = 30'd1050733751;
      3'd5: v = 30'd1062175488;
      3'd6: v = 30'd1067942999;
      3'd7: v = 30'd1070838487;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/gsc_sqrt.sv @@
module gsc_sqrt
  import gsc_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] in_v,
  output logic [15:0] out_root
);

  logic [17:0] rem_r  [SQRT_LAT];
  logic [15:0] root_r [SQRT_LAT];
  logic [31:0] v_r    [SQRT_LAT];

  // One result bit per stage, restoring digit recurrence
  generate
    for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stg
      logic [17:0] rem_p;
      logic [15:0] root_p;
      logic [31:0] v_p;
      logic [19:0] sh;
      logic [19:0] trial;
      logic        ge;

      if (i == 0) begin : g_first
        assign rem_p  = '0;
        assign root_p = '0;
        assign v_p    = in_v;
      end else begin : g_next
        assign rem_p  = rem_r[i-1];
        assign root_p = root_r[i-1];
        assign v_p    = v_r[i-1];
      end

      always_comb begin
        sh    = {rem_p, v_p[31:30]};
        trial = {2'b00, root_p, 2'b01};
        ge    = (sh >= trial);
      end

      always_ff @(posedge clk) begin
        rem_r[i]  <= ge ? 18'(sh - trial) : sh[17:0];
        root_r[i] <= {root_p[14:0], ge};
        v_r[i]    <= {v_p[29:0], 2'b00};
      end
    end
  endgenerate

  assign out_root = root_r[SQRT_LAT-1];

endmodule

@@ rtl/gsc_div.sv @@
module gsc_div
  import gsc_pkg::*;
#(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  output logic [NW-1:0] out_quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] q_r   [NW];
  logic [DW-1:0] den_r [NW];

  // Numerator shifts out the top while quotient bits shift in at the bottom
  generate
    for (genvar i = 0; i < NW; i++) begin : g_stg
      logic [DW-1:0] rem_p;
      logic [DW-1:0] den_p;
      logic [NW-1:0] q_p;
      logic [DW:0]   sh;
      logic          ge;

      if (i == 0) begin : g_first
        assign rem_p = '0;
        assign den_p = in_den;
        assign q_p   = in_num;
      end else begin : g_next
        assign rem_p = rem_r[i-1];
        assign den_p = den_r[i-1];
        assign q_p   = q_r[i-1];
      end

      always_comb begin
        sh = {rem_p, q_p[NW-1]};
        ge = (sh >= {1'b0, den_p});
      end

      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? DW'(sh - {1'b0, den_p}) : sh[DW-1:0];
        q_r[i]   <= {q_p[NW-2:0], ge};
        den_r[i] <= den_p;
      end
    end
  endgenerate

  assign out_quo = q_r[NW-1];

endmodule

@@ rtl/gsc_lik.sv @@
module gsc_lik
  import gsc_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] in_speed,
  input  logic [14:0] in_mean0,
  input  logic [14:0] in_sig0,
  input  logic [14:0] in_mean1,
  input  logic [14:0] in_sig1,
  output logic [47:0] out_e0,
  output logic [47:0] out_e1
);

  logic [14:0] mean_c [2];
  logic [14:0] sig_c  [2];
  logic [47:0] e_c    [2];

  assign mean_c[0] = in_mean0;
  assign mean_c[1] = in_mean1;
  assign sig_c[0]  = in_sig0;
  assign sig_c[1]  = in_sig1;
  assign out_e0    = e_c[0];
  assign out_e1    = e_c[1];

  generate
    for (genvar c = 0; c < 2; c++) begin : g_cls
      logic [15:0]        d_r;
      logic [31:0]        dd_r;
      logic [29:0]        ss_r;
      logic [A_NUM_W-1:0] q;
      logic [21:0]        a;
      logic [38:0]        bprod;
      logic [22:0]        b_r;
      logic [30:0]        m_r [8];
      logic [15:0]        f_r [7];
      logic [6:0]         n_r [8];
      logic [37:0]        tprod;
      logic [21:0]        t_r;
      logic [30:0]        cf;
      logic [61:0]        mfprod;
      logic [30:0]        mf_r;
      logic [6:0]         nf_r;
      logic [47:0]        e_r;

      always_ff @(posedge clk) begin
        d_r  <= (in_speed >= {1'b0, mean_c[c]}) ? 16'(in_speed - {1'b0, mean_c[c]})
                                                : 16'({1'b0, mean_c[c]} - in_speed);
        dd_r <= 32'(d_r) * 32'(d_r);
        ss_r <= 30'(sig_c[c]) * 30'(sig_c[c]);
      end

      // z^2/2 in Q16
      gsc_div #(.NW(A_NUM_W), .DW(A_DEN_W)) u_div (
        .clk     (clk),
        .in_num  ({dd_r, 15'd0}),
        .in_den  (ss_r),
        .out_quo (q)
      );

      // Clamp: anything at or above 2^22 already drives the exponent past range
      always_comb begin
        a     = (|q[A_NUM_W-1:22]) ? 22'h3F_FFFF : q[21:0];
        bprod = 39'(a) * 39'(LOG2E_Q16);
      end

      always_ff @(posedge clk) begin
        b_r <= bprod[38:16];
      end

      // Fractional power of two, one table factor per stage
      for (genvar k = 0; k < 8; k++) begin : g_man
        logic [30:0] m_p;
        logic [15:0] f_p;
        logic [6:0]  n_p;
        logic [60:0] prod;

        if (k == 0) begin : g_first
          assign m_p = ONE_Q30;
          assign f_p = b_r[15:0];
          assign n_p = b_r[22:16];
        end else begin : g_next
          assign m_p = m_r[k-1];
          assign f_p = f_r[k-1];
          assign n_p = n_r[k-1];
        end

        always_comb begin
          prod = 61'(m_p) * 61'(pow2_neg(3'(k)));
        end

        always_ff @(posedge clk) begin
          m_r[k] <= f_p[15-k] ? prod[60:30] : m_p;
          n_r[k] <= n_p;
        end

        if (k < 7) begin : g_f
          always_ff @(posedge clk) begin
            f_r[k] <= f_p;
          end
        end
      end

      always_comb begin
        tprod  = 38'(f_r[6][7:0]) * 38'(LN2_Q30);
        cf     = 31'(ONE_Q30 - {9'd0, t_r});
        mfprod = 62'(m_r[7]) * 62'(cf);
      end

      always_ff @(posedge clk) begin
        t_r  <= tprod[37:16];
        mf_r <= mfprod[60:30];
        nf_r <= n_r[7];
        e_r  <= (nf_r > EXP_MAX_N) ? 48'd0 : ({mf_r, 17'd0} >> nf_r[5:0]);
      end

      assign e_c[c] = e_r;
    end
  endgenerate

endmodule

@@ rtl/gaussian_slip_classifier_unit.sv @@
// Slip classifier for one leg sample per cycle.
// Input: start with in_leg_index, in_in_stance, in_vel_x, in_vel_y (Q4.12).
//   An item is taken on any clock edge with start high and busy low; busy
//   stays low, so a new item may enter every cycle.
// Output: out_valid pulses for one cycle with out_leg_out, out_slip_flag and
//   out_belief (posterior of slip, Q0.16). The receiver cannot stall; each
//   result appears exactly once, in input order.
// Throughput: one item per cycle. The depth comes from the bit-serial
//   pipelines: 16 square-root stages, 47 stages for z^2/2, 64 for the
//   prior/sigma weights and 63 for the final posterior quotient, plus the
//   exponent and glue stages.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while no item is in flight.
// Reset (synchronous, rst_n low): registers return to their defaults and all
//   in-flight items are dropped; no output strobes until new items arrive.
module gaussian_slip_classifier_unit
  import gsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_leg_index,
  input  logic               in_in_stance,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_leg_out,
  output logic               out_slip_flag,
  output logic [15:0]        out_belief
);

  typedef struct packed {
    logic       vld;
    logic [1:0] leg;
    logic       stance;
  } side_t;

  logic [15:0] slip_prior_r;
  logic [15:0] slip_threshold_r;
  logic [14:0] mean_no_slip_r;
  logic [14:0] sigma_no_slip_r;
  logic [14:0] mean_slipping_r;
  logic [14:0] sigma_slipping_r;
  logic [14:0] sig0;
  logic [14:0] sig1;

  side_t side_r [TOTAL_LAT];

  logic signed [15:0] vx_r;
  logic signed [15:0] vy_r;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [30:0]        sqx_r;
  logic [30:0]        sqy_r;
  logic [31:0]        sum_r;
  logic [15:0]        speed;
  logic [47:0]        e0;
  logic [47:0]        e1;
  logic [16:0]        pr0;
  logic [64:0]        p0;
  logic [63:0]        p1;
  logic [63:0]        w0n_r;
  logic [63:0]        w1n_r;
  logic [63:0]        w0q;
  logic [63:0]        w1q;
  logic [63:0]        den_r;
  logic [63:0]        w1d_r;
  logic [4:0]         k;
  logic [4:0]         k_r;
  logic [63:0]        den2_r;
  logic [63:0]        w1s_r;
  logic [63:0]        den_sh;
  logic [63:0]        w1_sh;
  logic [46:0]        dn_r;
  logic [46:0]        wn_r;
  logic [B_NUM_W-1:0] bq;
  logic [15:0]        bel;
  logic               slip_r;
  logic [15:0]        belief_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slip_prior_r     <= 16'd1311;
      slip_threshold_r <= 16'd32768;
      mean_no_slip_r   <= 15'd0;
      sigma_no_slip_r  <= 15'd1434;
      mean_slipping_r  <= 15'd1638;
      sigma_slipping_r <= 15'd6963;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLIP_PRIOR:     slip_prior_r     <= cfg_data;
        REG_SLIP_THRESHOLD: slip_threshold_r <= cfg_data;
        REG_MEAN_NO_SLIP:   mean_no_slip_r   <= cfg_data[14:0];
        REG_SIGMA_NO_SLIP:  sigma_no_slip_r  <= cfg_data[14:0];
        REG_MEAN_SLIPPING:  mean_slipping_r  <= cfg_data[14:0];
        REG_SIGMA_SLIPPING: sigma_slipping_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // A zero sigma acts as one
  assign sig0 = (sigma_no_slip_r == 15'd0) ? 15'd1 : sigma_no_slip_r;
  assign sig1 = (sigma_slipping_r == 15'd0) ? 15'd1 : sigma_slipping_r;

  // Valid, leg and stance ride alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else begin
      side_r[0] <= '{vld: start && !busy, leg: in_leg_index, stance: in_in_stance};
      for (int i = 1; i < TOTAL_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Speed squared
  assign px = 32'(vx_r) * 32'(vx_r);
  assign py = 32'(vy_r) * 32'(vy_r);

  always_ff @(posedge clk) begin
    vx_r  <= in_vel_x;
    vy_r  <= in_vel_y;
    sqx_r <= px[30:0];
    sqy_r <= py[30:0];
    sum_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  gsc_sqrt u_sqrt (
    .clk      (clk),
    .in_v     (sum_r),
    .out_root (speed)
  );

  gsc_lik u_lik (
    .clk      (clk),
    .in_speed (speed),
    .in_mean0 (mean_no_slip_r),
    .in_sig0  (sig0),
    .in_mean1 (mean_slipping_r),
    .in_sig1  (sig1),
    .out_e0   (e0),
    .out_e1   (e1)
  );

  // Prior-weighted likelihoods
  assign pr0 = 17'(17'h1_0000 - {1'b0, slip_prior_r});
  assign p0  = 65'(pr0) * 65'(e0);
  assign p1  = 64'(slip_prior_r) * 64'(e1);

  always_ff @(posedge clk) begin
    w0n_r <= p0[63:0];
    w1n_r <= p1;
  end

  gsc_div #(.NW(W_NUM_W), .DW(W_DEN_W)) u_div_w0 (
    .clk     (clk),
    .in_num  (w0n_r),
    .in_den  (sig0),
    .out_quo (w0q)
  );

  gsc_div #(.NW(W_NUM_W), .DW(W_DEN_W)) u_div_w1 (
    .clk     (clk),
    .in_num  (w1n_r),
    .in_den  (sig1),
    .out_quo (w1q)
  );

  // Bring the denominator under 2^47, dropping the same bits from W1
  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (den_r[47+i]) begin
        k = 5'(i + 1);
      end
    end
    den_sh = den2_r >> k_r;
    w1_sh  = w1s_r >> k_r;
  end

  always_ff @(posedge clk) begin
    den_r  <= w0q + w1q + EPS_W;
    w1d_r  <= w1q;
    k_r    <= k;
    den2_r <= den_r;
    w1s_r  <= w1d_r;
    dn_r   <= den_sh[46:0];
    wn_r   <= w1_sh[46:0];
  end

  gsc_div #(.NW(B_NUM_W), .DW(B_DEN_W)) u_div_b (
    .clk     (clk),
    .in_num  ({wn_r, 16'd0}),
    .in_den  (dn_r),
    .out_quo (bq)
  );

  assign bel = (|bq[B_NUM_W-1:16]) ? 16'hFFFF : bq[15:0];

  // Legs off the ground report no slip
  always_ff @(posedge clk) begin
    belief_r <= side_r[TOTAL_LAT-2].stance ? bel : 16'd0;
    slip_r   <= side_r[TOTAL_LAT-2].stance && (bel > slip_threshold_r);
  end

  assign out_valid     = side_r[TOTAL_LAT-1].vld;
  assign out_leg_out   = side_r[TOTAL_LAT-1].leg;
  assign out_slip_flag = slip_r;
  assign out_belief    = belief_r;

endmodule

@@ rtl/gsc_checker.sv @@
module gsc_checker
  import gsc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_leg_index,
  input logic        in_in_stance,
  input logic        out_valid,
  input logic [1:0]  out_leg_out,
  input logic        out_slip_flag,
  input logic [15:0] out_belief
);

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without an accepted item");

  a_leg_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_leg_out == $past(in_leg_index, TOTAL_LAT))
    else $error("leg index not echoed");

  a_swing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(in_in_stance, TOTAL_LAT) |-> out_belief == 16'd0 && !out_slip_flag)
    else $error("swing leg reported belief");

  a_slip_belief: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slip_flag |-> out_belief != 16'd0)
    else $error("slip with zero belief");

endmodule

bind gaussian_slip_classifier_unit gsc_checker u_gsc_checker (.*);

@@ tb/gaussian_slip_classifier_unit_test.sv @@
`timescale 1ns / 100ps

module gaussian_slip_classifier_unit_test;
  import gsc_pkg::*;

  typedef struct packed {
    logic [1:0]         leg;
    logic               stance;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } leg_sample_t;

  typedef struct packed {
    logic [1:0]  leg;
    logic        slip;
    logic [15:0] belief;
  } slip_verdict_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_leg_index = '0;
  logic in_in_stance = 1'b0;
  logic signed [15:0] in_vel_x = '0;
  logic signed [15:0] in_vel_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic [1:0] out_leg_out;
  logic out_slip_flag;
  logic [15:0] out_belief;

  // predictor copy of the configuration
  logic [15:0] prior_q;
  logic [15:0] thresh_q;
  logic [14:0] mean_grip;
  logic [14:0] sigma_grip;
  logic [14:0] mean_slide;
  logic [14:0] sigma_slide;

  leg_sample_t   sample_queue[$];
  slip_verdict_t verdict_queue[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  bit quiet = 1'b0;

  gaussian_slip_classifier_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_leg_index(in_leg_index), .in_in_stance(in_in_stance),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_leg_out(out_leg_out),
    .out_slip_flag(out_slip_flag), .out_belief(out_belief)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc = 0;
    bitv = 64'd1 << 32;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // exp(-(s-mean)^2 / (2 sigma^2)) in Q47
  function automatic logic [63:0] gauss_q47(input logic [63:0] s, input logic [63:0] mean,
                                            input logic [63:0] sig);
    logic [63:0] d, a, b, n, f, m;
    logic [63:0] steps[8];
    steps = '{64'd759250125, 64'd902905651, 64'd984625595, 64'd1028218693,
              64'd1050733751, 64'd1062175488, 64'd1067942999, 64'd1070838487};
    d = (s >= mean) ? s - mean : mean - s;
    a = ((d * d) << 15) / (sig * sig);
    b = (a * 64'd94548) >> 16;
    n = b >> 16;
    f = b & 64'hFFFF;
    m = 64'd1 << 30;
    if (n > 47) return 64'd0;
    for (int k = 0; k < 8; k++)
      if (f[15-k]) m = (m * steps[k]) >> 30;
    m = (m * ((64'd1 << 30) - (((f & 64'hFF) * 64'd744261118) >> 16))) >> 30;
    return (m << 17) >> n;
  endfunction

  function automatic slip_verdict_t classify(input leg_sample_t it);
    slip_verdict_t r;
    logic [63:0] sq, s, sg0, sg1, e0, e1, w0, w1, den, bel;
    longint vx, vy;
    r.leg = it.leg;
    r.slip = 1'b0;
    r.belief = '0;
    if (it.stance) begin
      vx = it.vx;
      vy = it.vy;
      sq = vx * vx + vy * vy;
      s = floor_sqrt(sq);
      sg0 = (sigma_grip == 0) ? 64'd1 : 64'(sigma_grip);
      sg1 = (sigma_slide == 0) ? 64'd1 : 64'(sigma_slide);
      e0 = gauss_q47(s, 64'(mean_grip), sg0);
      e1 = gauss_q47(s, 64'(mean_slide), sg1);
      w0 = ((64'd65536 - 64'(prior_q)) * e0) / sg0;
      w1 = (64'(prior_q) * e1) / sg1;
      den = w0 + w1 + 64'd5645;
      while (den >= (64'd1 << 47)) begin
        den = den >> 1;
        w1 = w1 >> 1;
      end
      bel = (w1 << 16) / den;
      if (bel > 64'd65535) bel = 64'd65535;
      r.belief = bel[15:0];
      r.slip = (bel > 64'(thresh_q));
    end
    return r;
  endfunction

  function automatic leg_sample_t make_sample(input int leg, input int stance, input int vx,
                                              input int vy);
    leg_sample_t it;
    it.leg = leg[1:0];
    it.stance = stance[0];
    it.vx = vx[15:0];
    it.vy = vy[15:0];
    return it;
  endfunction

  // mostly stance samples around the class means, some full-range and swing
  function automatic leg_sample_t random_sample();
    int mode, span, vx, vy;
    mode = $urandom_range(0, 9);
    vx = $urandom_range(0, 65535) - 32768;
    vy = $urandom_range(0, 65535) - 32768;
    if (mode < 6) begin
      span = int'(mean_slide) + 4 * int'(sigma_slide);
      if (span > 32767) span = 32767;
      vx = $urandom_range(0, span);
      vy = $urandom_range(0, span / 4);
      if ($urandom_range(0, 1)) vx = -vx;
      if ($urandom_range(0, 1)) vy = -vy;
    end
    return make_sample($urandom_range(0, 3), (mode == 9) ? 0 : 1, vx, vy);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SLIP_PRIOR:     prior_q = val;
      REG_SLIP_THRESHOLD: thresh_q = val;
      REG_MEAN_NO_SLIP:   mean_grip = val[14:0];
      REG_SIGMA_NO_SLIP:  sigma_grip = val[14:0];
      REG_MEAN_SLIPPING:  mean_slide = val[14:0];
      REG_SIGMA_SLIPPING: sigma_slide = val[14:0];
      default: ;
    endcase
  endtask

  // look at the falling edge, once the driver's updates have settled
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || start || verdict_queue.size() != 0);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) sample_queue.push_back(random_sample());
    drain();
  endtask

  task automatic load_cfg(input logic [15:0] p, input logic [15:0] t, input logic [15:0] m0,
                          input logic [15:0] s0, input logic [15:0] m1, input logic [15:0] s1);
    write_reg(REG_SLIP_PRIOR, p);
    write_reg(REG_SLIP_THRESHOLD, t);
    write_reg(REG_MEAN_NO_SLIP, m0);
    write_reg(REG_SIGMA_NO_SLIP, s0);
    write_reg(REG_MEAN_SLIPPING, m1);
    write_reg(REG_SIGMA_SLIPPING, s1);
  endtask

  // driver: record the accepted item, then present the next one or idle
  always @(posedge clk) begin
    leg_sample_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        verdict_queue.push_back(classify(make_sample(in_leg_index, in_in_stance,
                                                     in_vel_x, in_vel_y)));
      if (start && busy) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        gap_left <= $urandom_range(1, 12) - 1;
        start <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        nxt = sample_queue.pop_front();
        start <= 1'b1;
        in_leg_index <= nxt.leg;
        in_in_stance <= nxt.stance;
        in_vel_x <= nxt.vx;
        in_vel_y <= nxt.vy;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    slip_verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item leg=%0d slip=%0d belief=%0d",
                                       out_leg_out, out_slip_flag, out_belief);
      end else begin
        want = verdict_queue.pop_front();
        if (want.leg !== out_leg_out || want.slip !== out_slip_flag ||
            want.belief !== out_belief) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected leg=%0d slip=%0d belief=%0d, got %0d %0d %0d",
                     want.leg, want.slip, want.belief, out_leg_out, out_slip_flag,
                     out_belief);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    prior_q = 16'd1311;
    thresh_q = 16'd32768;
    mean_grip = 15'd0;
    sigma_grip = 15'd1434;
    mean_slide = 15'd1638;
    sigma_slide = 15'd6963;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: swing, zero speed, extremes, around the means, far tails
    sample_queue.push_back(make_sample(0, 0, 32767, -32768));
    sample_queue.push_back(make_sample(1, 1, 0, 0));
    sample_queue.push_back(make_sample(2, 1, -32768, -32768));
    sample_queue.push_back(make_sample(3, 1, 32767, 32767));
    sample_queue.push_back(make_sample(0, 1, -32768, 0));
    sample_queue.push_back(make_sample(1, 1, 0, 32767));
    sample_queue.push_back(make_sample(2, 1, 1638, 0));
    sample_queue.push_back(make_sample(3, 1, 0, -1434));
    sample_queue.push_back(make_sample(0, 1, 800, 800));
    sample_queue.push_back(make_sample(1, 1, -3000, 2000));
    sample_queue.push_back(make_sample(2, 1, 20000, -100));
    sample_queue.push_back(make_sample(3, 0, 0, 0));
    sample_queue.push_back(make_sample(0, 1, -1, -1));
    drain();

    run_random(200);
    load_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    // far from a unit sigma both weights underflow
    sample_queue.push_back(make_sample(1, 1, 5000, 0));
    sample_queue.push_back(make_sample(2, 1, 0, 0));
    run_random(120);
    load_cfg(16'd65535, 16'd65535, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    run_random(150);
    load_cfg(16'd32768, 16'd0, 16'd200, 16'd300, 16'd2000, 16'd50);
    run_random(150);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    load_cfg(16'd65535, 16'd100, 16'hFFFF, 16'd1, 16'd0, 16'd40);
    run_random(150);
    for (int p = 0; p < 3; p++) begin
      load_cfg(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 8000)), 16'($urandom_range(1, 8000)),
               16'($urandom_range(0, 12000)), 16'($urandom_range(1, 12000)));
      run_random(150);
    end
    quiet = 1'b1;
    run_random(100);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
